[sv/stc_pkg.sv]
// Shared types, codes and helpers for the sensor trim compensation block.
// No dependencies; sensor_trim_compensation refers to it by scoped names.
package stc_pkg;

    localparam logic [19:0] SKIP_20    = 20'h80000;
    localparam logic [15:0] SKIP_16    = 16'h8000;
    localparam logic [63:0] HUM_MAX    = 64'd419430400;
    localparam logic [63:0] T_OFFSET   = 64'd128000;
    localparam logic [63:0] H_OFFSET   = 64'd76800;
    localparam logic [63:0] P_BASE     = 64'd1048576;
    localparam logic [63:0] P_SCALE    = 64'd3125;
    localparam logic [63:0] P_ONE_47   = 64'h0000_8000_0000_0000;

    localparam logic [2:0] REG_TEMP    = 3'd0;
    localparam logic [2:0] REG_PRESS_L = 3'd1;
    localparam logic [2:0] REG_PRESS_H = 3'd2;
    localparam logic [2:0] REG_P9_HUM  = 3'd3;
    localparam logic [2:0] REG_HUM     = 3'd4;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic               temperature_valid;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
        logic [16:0]        humidity_q22_10;
        logic               humidity_valid;
    } t_out_item;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_T_PREP, ST_T_MUL_V1, ST_T_MUL_D2, ST_T_MUL_T3, ST_T_FINE, ST_T_OUT,
        ST_P_PREP, ST_P_MUL_AA, ST_P_MUL_P6, ST_P_MUL_P5, ST_P_ADD_P4,
        ST_P_MUL_P3, ST_P_MUL_P2, ST_P_ADD47, ST_P_MUL_P1, ST_P_CHECK,
        ST_P_MUL_3125, ST_P_DIV, ST_P_MUL_P9A, ST_P_MUL_P9B, ST_P_MUL_P8,
        ST_P_SUM, ST_P_OUT,
        ST_H_PREP, ST_H_MUL_H5, ST_H_A1, ST_H_A2, ST_H_MUL_H6, ST_H_MUL_H3,
        ST_H_MUL_B, ST_H_MUL_H2, ST_H_MUL_V, ST_H_MUL_VV, ST_H_MUL_H1,
        ST_H_OUT, ST_DONE
    } t_state;

    function automatic logic [63:0] f_asr(input logic [63:0] v, input logic [5:0] n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] f_sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

[sv/stc_serial_mul.sv]
// Bit-serial shift-add multiplier, low 64 bits of the product.
// Uses no package items; instantiated by sensor_trim_compensation.
module stc_serial_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mc, n_mc;
    logic [63:0] r_mp, n_mp;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_acc  = 64'd0;
            n_mc   = i_a;
            n_mp   = i_b;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                n_acc = r_acc + r_mc;
            end
            n_mc  = {r_mc[62:0], 1'b0};
            n_mp  = {1'b0, r_mp[63:1]};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[sv/stc_serial_div.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Uses no package items; instantiated by sensor_trim_compensation.
module stc_serial_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [63:0] r_d, n_d;
    logic [63:0] r_rem, n_rem;
    logic [64:0] s_sh, s_diff;

    assign s_sh   = {r_rem, r_q[63]};
    assign s_diff = s_sh - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_d    = r_d;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = 64'd0;
            n_neg  = i_num[63] ^ i_den[63];
            n_q    = i_num[63] ? (64'd0 - i_num) : i_num;
            n_d    = i_den[63] ? (64'd0 - i_den) : i_den;
        end else if (r_busy) begin
            // no borrow: shifted remainder covers the divisor
            if (!s_diff[64]) begin
                n_rem = s_diff[63:0];
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = s_sh[63:0];
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_d   <= n_d;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (64'd0 - r_q) : r_q;

endmodule

[sv/sensor_trim_compensation.sv]
// Top level of the sensor trim compensation block.
// Depends on stc_pkg, stc_serial_mul and stc_serial_div.
//
// Usage:
//  Input channel (i_valid / o_ready, payload i_sample) carries one raw sample:
//  temperature, pressure and humidity conversions. Output channel
//  (o_valid / i_ready, payload o_result) carries one compensated result per
//  sample, in order.
//  Trim coefficients are written over the APB-style port (8-byte slots,
//  index in paddr[5:3]); pready is tied high, prdata reads back the register.
//  Write coefficients only while the block is idle.
//  Throughput: one sample at a time. Each 64-bit product runs on a
//  bit-serial multiplier, the pressure quotient on a bit-serial divider.
//  A full sample takes 21 products and one quotient plus about 15 add
//  steps; skipped channels drop their share (temperature 3 products,
//  pressure 10 + divide, humidity 8).
//  Reset: coefficients and the stored fine temperature clear to zero, both
//  channels go idle.
//  Stall: the finished result sits in an output register; a new sample is
//  taken meanwhile, and only its completion waits for the register to free.
module sensor_trim_compensation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  stc_pkg::t_in_item   i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output stc_pkg::t_out_item  o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    // coefficient registers
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [47:0] r_p9_hum;
    logic [47:0] r_hum_coeffs;

    logic        s_wr;
    assign pready = 1'b1;
    assign s_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= 48'd0;
            r_press_lo    <= 64'd0;
            r_press_hi    <= 64'd0;
            r_p9_hum      <= 48'd0;
            r_hum_coeffs  <= 48'd0;
        end else if (s_wr) begin
            case (paddr[5:3])
                stc_pkg::REG_TEMP:    r_temp_coeffs <= pwdata[47:0];
                stc_pkg::REG_PRESS_L: r_press_lo    <= pwdata;
                stc_pkg::REG_PRESS_H: r_press_hi    <= pwdata;
                stc_pkg::REG_P9_HUM:  r_p9_hum      <= pwdata[47:0];
                stc_pkg::REG_HUM:     r_hum_coeffs  <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            stc_pkg::REG_TEMP:    prdata = {16'd0, r_temp_coeffs};
            stc_pkg::REG_PRESS_L: prdata = r_press_lo;
            stc_pkg::REG_PRESS_H: prdata = r_press_hi;
            stc_pkg::REG_P9_HUM:  prdata = {16'd0, r_p9_hum};
            stc_pkg::REG_HUM:     prdata = {16'd0, r_hum_coeffs};
            default:              prdata = 64'd0;
        endcase
    end

    // coefficient fields, extended to 64 bits
    logic [63:0] c_t1, c_t2, c_t3;
    logic [63:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
    logic [63:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

    assign c_t1 = {48'd0, r_temp_coeffs[15:0]};
    assign c_t2 = stc_pkg::f_sext16(r_temp_coeffs[31:16]);
    assign c_t3 = stc_pkg::f_sext16(r_temp_coeffs[47:32]);
    assign c_p1 = {48'd0, r_press_lo[15:0]};
    assign c_p2 = stc_pkg::f_sext16(r_press_lo[31:16]);
    assign c_p3 = stc_pkg::f_sext16(r_press_lo[47:32]);
    assign c_p4 = stc_pkg::f_sext16(r_press_lo[63:48]);
    assign c_p5 = stc_pkg::f_sext16(r_press_hi[15:0]);
    assign c_p6 = stc_pkg::f_sext16(r_press_hi[31:16]);
    assign c_p7 = stc_pkg::f_sext16(r_press_hi[47:32]);
    assign c_p8 = stc_pkg::f_sext16(r_press_hi[63:48]);
    assign c_p9 = stc_pkg::f_sext16(r_p9_hum[15:0]);
    assign c_h1 = {56'd0, r_p9_hum[23:16]};
    assign c_h2 = stc_pkg::f_sext16(r_p9_hum[39:24]);
    assign c_h3 = {56'd0, r_p9_hum[47:40]};
    assign c_h4 = stc_pkg::f_sext16(r_hum_coeffs[15:0]);
    assign c_h5 = stc_pkg::f_sext16(r_hum_coeffs[31:16]);
    assign c_h6 = stc_pkg::f_sext16(r_hum_coeffs[47:32]);

    // sequencer state and working registers
    stc_pkg::t_state r_state, n_state;
    logic        r_wait, n_wait;        // a multiply or divide is in flight
    logic [31:0] r_fine, n_fine;        // stored fine temperature
    logic [63:0] r_ra, n_ra, r_rb, n_rb, r_rc, n_rc, r_rd, n_rd;
    stc_pkg::t_in_item r_sample, n_sample;
    logic        r_tv, n_tv, r_pv, n_pv, r_hv, n_hv;
    logic [31:0] r_temp, n_temp;
    logic [31:0] r_press, n_press;
    logic [16:0] r_humid, n_humid;
    stc_pkg::t_out_item r_result, n_result;
    logic        r_out_valid, n_out_valid;

    logic        s_mul_op, s_div_op, s_mul_start, s_div_start;
    logic [63:0] s_mul_a, s_mul_b;
    logic        w_mul_done, w_div_done;
    logic [63:0] w_mul_prod, w_div_quot;
    logic [63:0] s_fe;
    logic        s_accept;

    assign s_fe     = {{32{r_fine[31]}}, r_fine};
    assign o_ready  = (r_state == stc_pkg::ST_IDLE);
    assign s_accept = i_valid & o_ready;
    assign s_mul_start = s_mul_op & ~r_wait;
    assign s_div_start = s_div_op & ~r_wait;

    stc_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_mul_start),
        .i_a     (s_mul_a),
        .i_b     (s_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    stc_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_num   (r_rb),
        .i_den   (r_ra),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        logic [63:0]     v_tmp;
        logic            v_done;
        stc_pkg::t_state v_after_t, v_after_p;

        n_state     = r_state;
        n_fine      = r_fine;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_rc        = r_rc;
        n_rd        = r_rd;
        n_sample    = r_sample;
        n_tv        = r_tv;
        n_pv        = r_pv;
        n_hv        = r_hv;
        n_temp      = r_temp;
        n_press     = r_press;
        n_humid     = r_humid;
        n_result    = r_result;
        n_out_valid = r_out_valid & ~i_ready;
        s_mul_op    = 1'b0;
        s_div_op    = 1'b0;
        s_mul_a     = 64'd0;
        s_mul_b     = 64'd0;
        v_tmp       = 64'd0;
        v_done      = w_mul_done | w_div_done;

        // skipped channels fall through to the next one
        if (r_pv) begin
            v_after_t = stc_pkg::ST_P_PREP;
        end else if (r_hv) begin
            v_after_t = stc_pkg::ST_H_PREP;
        end else begin
            v_after_t = stc_pkg::ST_DONE;
        end
        v_after_p = r_hv ? stc_pkg::ST_H_PREP : stc_pkg::ST_DONE;

        case (r_state)
            stc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_sample = i_sample;
                    n_tv     = (i_sample.raw_temperature != stc_pkg::SKIP_20);
                    n_pv     = (i_sample.raw_pressure != stc_pkg::SKIP_20);
                    n_hv     = (i_sample.raw_humidity != stc_pkg::SKIP_16);
                    n_temp   = 32'd0;
                    n_press  = 32'd0;
                    n_humid  = 17'd0;
                    n_state  = stc_pkg::ST_T_PREP;
                end
            end
            // ---- temperature ----
            stc_pkg::ST_T_PREP: begin
                n_ra = {47'd0, r_sample.raw_temperature[19:3]}
                     - {47'd0, r_temp_coeffs[15:0], 1'b0};
                n_rb = {48'd0, r_sample.raw_temperature[19:4]} - c_t1;
                n_state = r_tv ? stc_pkg::ST_T_MUL_V1 : v_after_t;
            end
            stc_pkg::ST_T_MUL_V1: begin
                s_mul_op = 1'b1; s_mul_a = r_ra; s_mul_b = c_t2;
                if (w_mul_done) begin
                    n_ra = stc_pkg::f_asr(w_mul_prod, 6'd11);
                    n_state = stc_pkg::ST_T_MUL_D2;
                end
            end
            stc_pkg::ST_T_MUL_D2: begin
                s_mul_op = 1'b1; s_mul_a = r_rb; s_mul_b = r_rb;
                if (w_mul_done) begin
                    n_rb = stc_pkg::f_asr(w_mul_prod, 6'd12);
                    n_state = stc_pkg::ST_T_MUL_T3;
                end
            end
            stc_pkg::ST_T_MUL_T3: begin
                s_mul_op = 1'b1; s_mul_a = r_rb; s_mul_b = c_t3;
                if (w_mul_done) begin
                    n_rb = stc_pkg::f_asr(w_mul_prod, 6'd14);
                    n_state = stc_pkg::ST_T_FINE;
                end
            end
            stc_pkg::ST_T_FINE: begin
                n_fine  = r_ra[31:0] + r_rb[31:0];
                n_state = stc_pkg::ST_T_OUT;
            end
            stc_pkg::ST_T_OUT: begin
                // fine * 5 as shift plus add
                v_tmp   = stc_pkg::f_asr({s_fe[61:0], 2'b00} + s_fe + 64'd128, 6'd8);
                n_temp  = v_tmp[31:0];
                n_state = v_after_t;
            end
            // ---- pressure ----
            stc_pkg::ST_P_PREP: begin
                n_ra    = s_fe - stc_pkg::T_OFFSET;
                n_state = stc_pkg::ST_P_MUL_AA;
            end
            stc_pkg::ST_P_MUL_AA: begin
                s_mul_op = 1'b1; s_mul_a = r_ra; s_mul_b = r_ra;
                if (w_mul_done) begin
                    n_rb = w_mul_prod;
                    n_state = stc_pkg::ST_P_MUL_P6;
                end
            end
            stc_pkg::ST_P_MUL_P6: begin
                s_mul_op = 1'b1; s_mul_a = r_rb; s_mul_b = c_p6;
                if (w_mul_done) begin
                    n_rc = w_mul_prod;
                    n_state = stc_pkg::ST_P_MUL_P5;
                end
            end
            stc_pkg::ST_P_MUL_P5: begin
                s_mul_op = 1'b1; s_mul_a = r_ra; s_mul_b = c_p5;
                if (w_mul_done) begin
                    n_rc = r_rc + {w_mul_prod[46:0], 17'd0};
                    n_state = stc_pkg::ST_P_ADD_P4;
                end
            end
            stc_pkg::ST_P_ADD_P4: begin
                n_rc    = r_rc + {c_p4[28:0], 35'd0};
                n_state = stc_pkg::ST_P_MUL_P3;
            end
            stc_pkg::ST_P_MUL_P3: begin
                s_mul_op = 1'b1; s_mul_a = r_rb; s_mul_b = c_p3;
                if (w_mul_done) begin
                    n_rd = stc_pkg::f_asr(w_mul_prod, 6'd8);
                    n_state = stc_pkg::ST_P_MUL_P2;
                end
            end
            stc_pkg::ST_P_MUL_P2: begin
                s_mul_op = 1'b1; s_mul_a = r_ra; s_mul_b = c_p2;
                if (w_mul_done) begin
                    n_ra = r_rd + {w_mul_prod[51:0], 12'd0};
                    n_state = stc_pkg::ST_P_ADD47;
                end
            end
            stc_pkg::ST_P_ADD47: begin
                n_ra    = stc_pkg::P_ONE_47 + r_ra;
                n_state = stc_pkg::ST_P_MUL_P1;
            end
            stc_pkg::ST_P_MUL_P1: begin
                s_mul_op = 1'b1; s_mul_a = r_ra; s_mul_b = c_p1;
                if (w_mul_done) begin
                    n_ra = stc_pkg::f_asr(w_mul_prod, 6'd33);
                    n_state = stc_pkg::ST_P_CHECK;
                end
            end
            stc_pkg::ST_P_CHECK: begin
                // zero divisor: pressure reads 0 but stays valid
                if (r_ra == 64'd0) begin
                    n_press = 32'd0;
                    n_state = v_after_p;
                end else begin
                    v_tmp   = stc_pkg::P_BASE - {44'd0, r_sample.raw_pressure};
                    n_rb    = {v_tmp[32:0], 31'd0} - r_rc;
                    n_state = stc_pkg::ST_P_MUL_3125;
                end
            end
            stc_pkg::ST_P_MUL_3125: begin
                s_mul_op = 1'b1; s_mul_a = r_rb; s_mul_b = stc_pkg::P_SCALE;
                if (w_mul_done) begin
                    n_rb = w_mul_prod;
                    n_state = stc_pkg::ST_P_DIV;
                end
            end
            stc_pkg::ST_P_DIV: begin
                s_div_op = 1'b1;
                if (w_div_done) begin
                    n_rb = w_div_quot;
                    n_rc = stc_pkg::f_asr(w_div_quot, 6'd13);
                    n_state = stc_pkg::ST_P_MUL_P9A;
                end
            end
            stc_pkg::ST_P_MUL_P9A: begin
                s_mul_op = 1'b1; s_mul_a = c_p9; s_mul_b = r_rc;
                if (w_mul_done) begin
                    n_rd = w_mul_prod;
                    n_state = stc_pkg::ST_P_MUL_P9B;
                end
            end
            stc_pkg::ST_P_MUL_P9B: begin
                s_mul_op = 1'b1; s_mul_a = r_rd; s_mul_b = r_rc;
                if (w_mul_done) begin
                    n_rd = stc_pkg::f_asr(w_mul_prod, 6'd25);
                    n_state = stc_pkg::ST_P_MUL_P8;
                end
            end
            stc_pkg::ST_P_MUL_P8: begin
                s_mul_op = 1'b1; s_mul_a = c_p8; s_mul_b = r_rb;
                if (w_mul_done) begin
                    n_rc = stc_pkg::f_asr(w_mul_prod, 6'd19);
                    n_state = stc_pkg::ST_P_SUM;
                end
            end
            stc_pkg::ST_P_SUM: begin
                n_rb    = r_rb + r_rd + r_rc;
                n_state = stc_pkg::ST_P_OUT;
            end
            stc_pkg::ST_P_OUT: begin
                v_tmp   = stc_pkg::f_asr(r_rb, 6'd8) + {c_p7[59:0], 4'd0};
                n_press = v_tmp[31:0];
                n_state = v_after_p;
            end
            // ---- humidity ----
            stc_pkg::ST_H_PREP: begin
                n_ra    = s_fe - stc_pkg::H_OFFSET;
                n_state = stc_pkg::ST_H_MUL_H5;
            end
            stc_pkg::ST_H_MUL_H5: begin
                s_mul_op = 1'b1; s_mul_a = c_h5; s_mul_b = r_ra;
                if (w_mul_done) begin
                    n_rb = w_mul_prod;
                    n_state = stc_pkg::ST_H_A1;
                end
            end
            stc_pkg::ST_H_A1: begin
                n_rc = {34'd0, r_sample.raw_humidity, 14'd0}
                     - {c_h4[43:0], 20'd0} - r_rb;
                n_state = stc_pkg::ST_H_A2;
            end
            stc_pkg::ST_H_A2: begin
                n_rc    = stc_pkg::f_asr(r_rc + 64'd16384, 6'd15);
                n_state = stc_pkg::ST_H_MUL_H6;
            end
            stc_pkg::ST_H_MUL_H6: begin
                s_mul_op = 1'b1; s_mul_a = r_ra; s_mul_b = c_h6;
                if (w_mul_done) begin
                    n_rb = stc_pkg::f_asr(w_mul_prod, 6'd10);
                    n_state = stc_pkg::ST_H_MUL_H3;
                end
            end
            stc_pkg::ST_H_MUL_H3: begin
                s_mul_op = 1'b1; s_mul_a = r_ra; s_mul_b = c_h3;
                if (w_mul_done) begin
                    n_rd = stc_pkg::f_asr(w_mul_prod, 6'd11) + 64'd32768;
                    n_state = stc_pkg::ST_H_MUL_B;
                end
            end
            stc_pkg::ST_H_MUL_B: begin
                s_mul_op = 1'b1; s_mul_a = r_rb; s_mul_b = r_rd;
                if (w_mul_done) begin
                    n_rb = stc_pkg::f_asr(w_mul_prod, 6'd10) + 64'd2097152;
                    n_state = stc_pkg::ST_H_MUL_H2;
                end
            end
            stc_pkg::ST_H_MUL_H2: begin
                s_mul_op = 1'b1; s_mul_a = r_rb; s_mul_b = c_h2;
                if (w_mul_done) begin
                    n_rb = stc_pkg::f_asr(w_mul_prod + 64'd8192, 6'd14);
                    n_state = stc_pkg::ST_H_MUL_V;
                end
            end
            stc_pkg::ST_H_MUL_V: begin
                s_mul_op = 1'b1; s_mul_a = r_rc; s_mul_b = r_rb;
                if (w_mul_done) begin
                    n_rc = w_mul_prod;
                    n_rd = stc_pkg::f_asr(w_mul_prod, 6'd15);
                    n_state = stc_pkg::ST_H_MUL_VV;
                end
            end
            stc_pkg::ST_H_MUL_VV: begin
                s_mul_op = 1'b1; s_mul_a = r_rd; s_mul_b = r_rd;
                if (w_mul_done) begin
                    n_rd = stc_pkg::f_asr(w_mul_prod, 6'd7);
                    n_state = stc_pkg::ST_H_MUL_H1;
                end
            end
            stc_pkg::ST_H_MUL_H1: begin
                s_mul_op = 1'b1; s_mul_a = r_rd; s_mul_b = c_h1;
                if (w_mul_done) begin
                    n_rd = stc_pkg::f_asr(w_mul_prod, 6'd4);
                    n_state = stc_pkg::ST_H_OUT;
                end
            end
            stc_pkg::ST_H_OUT: begin
                // clamp to 0 .. 100 percent before the final scale
                v_tmp = r_rc - r_rd;
                if (v_tmp[63]) begin
                    v_tmp = 64'd0;
                end else if (v_tmp > stc_pkg::HUM_MAX) begin
                    v_tmp = stc_pkg::HUM_MAX;
                end
                n_humid = v_tmp[28:12];
                n_state = stc_pkg::ST_DONE;
            end
            stc_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_result.temperature_centi = r_temp;
                    n_result.temperature_valid = r_tv;
                    n_result.pressure_q24_8    = r_press;
                    n_result.pressure_valid    = r_pv;
                    n_result.humidity_q22_10   = r_humid;
                    n_result.humidity_valid    = r_hv;
                    n_out_valid = 1'b1;
                    n_state     = stc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stc_pkg::ST_IDLE;
            end
        endcase

        if (s_mul_start || s_div_start) begin
            n_wait = 1'b1;
        end else if (v_done) begin
            n_wait = 1'b0;
        end else begin
            n_wait = r_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stc_pkg::ST_IDLE;
            r_wait      <= 1'b0;
            r_fine      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_fine      <= n_fine;
            r_out_valid <= n_out_valid;
        end
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_rc     <= n_rc;
        r_rd     <= n_rd;
        r_sample <= n_sample;
        r_tv     <= n_tv;
        r_pv     <= n_pv;
        r_hv     <= n_hv;
        r_temp   <= n_temp;
        r_press  <= n_press;
        r_humid  <= n_humid;
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // an arithmetic unit only reports completion for an issued operation
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_done || w_div_done) |-> r_wait)
        else $error("arith done without an operation in flight");

    // never issue while a unit is still working
    a_no_double_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_mul_start || s_div_start) |=> !(s_mul_start || s_div_start))
        else $error("operation issued twice back to back");

    // an accepted sample always starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == stc_pkg::ST_T_PREP))
        else $error("accepted sample did not start compensation");

    // a finished sample waits while the output register is still occupied
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stc_pkg::ST_DONE && r_out_valid && !i_ready)
        |=> (r_state == stc_pkg::ST_DONE))
        else $error("result overwrote a pending transfer");

endmodule
